FILE: hw/rtl/utf8d_pkg.sv
package utf8d_pkg;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] LEAD2_MIN  = 8'hC0;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT = 8'hF5;
    localparam logic [5:0] PAY_MASK   = 6'h3F;

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ASCII = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    localparam logic [20:0] MIN_TWO   = 21'h000080;
    localparam logic [20:0] MIN_THREE = 21'h000800;
    localparam logic [20:0] MIN_FOUR  = 21'h010000;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [20:0] cp;
        logic        inv;
    } result_t;

    // sequence length opened by a byte; LEN_NONE for bytes that cannot start one
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < CONT_MARK)
            len = LEN_ASCII;
        else if (b < LEAD2_MIN)
            len = LEN_NONE;
        else if (b < LEAD3_MIN)
            len = LEN_TWO;
        else if (b < LEAD4_MIN)
            len = LEN_THREE;
        else if (b < LEAD_LIMIT)
            len = LEN_FOUR;
        else
            len = LEN_NONE;
        return len;
    endfunction

endpackage

FILE: hw/rtl/utf8_stream_decoder.sv
// channel | signals                               | dir | notes
// --------+---------------------------------------+-----+---------------------------
// in      | in_valid, in_ready, data_byte,        | in  | one raw byte per
//         | end_of_data                           |     | transaction
// out     | out_valid, out_ready, code_point,     | out | one code point or invalid
//         | invalid_byte, last_of_run             |     | raw byte per transaction
//
// A byte is decoded in the cycle it is accepted and its 0..4 results land in a
// result buffer that drives the output; the buffer drains one result per cycle while out_ready is high.
// Throughput is one byte per cycle while each byte gives at most one result and the output does not stall; a byte
// that gives more results (error flushes) holds in_ready low until all but its last result have been taken.
// rst_n clears the sequence state and empties the result buffer.
// A stalled output holds the buffer; in_ready is high again in the cycle the last
// buffered result is taken.
module utf8_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic        invalid_byte,
    output logic        last_of_run
);

    // open sequence
    logic [7:0] lead_reg, lead_next;
    logic [2:0] len_reg, len_next;
    logic [1:0] ccnt_reg, ccnt_next;
    logic [5:0] pay_reg [3];

    // result buffer
    utf8d_pkg::result_t buf_reg [utf8d_pkg::MAX_RESULTS];
    utf8d_pkg::result_t res_next [utf8d_pkg::MAX_RESULTS];
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg;

    logic in_fire, out_fire, last_one;
    logic is_cont, open_seq, cont_in_seq;

    assign last_one  = (cnt_reg - {1'b0, rd_reg}) == 3'd1;
    assign out_valid = cnt_reg != 3'd0;
    assign in_ready  = (cnt_reg == 3'd0) || (out_ready && last_one);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    assign code_point   = buf_reg[rd_reg].cp;
    assign invalid_byte = buf_reg[rd_reg].inv;
    assign last_of_run  = last_one;

    assign is_cont     = (data_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_MARK;
    assign open_seq    = len_reg != utf8d_pkg::LEN_NONE;
    assign cont_in_seq = open_seq && is_cont;

    always_comb
    begin
        logic [2:0]  n;
        logic [5:0]  pe [3];
        logic [2:0]  ncnt;
        logic        fin;
        logic [20:0] u;
        logic        good;
        logic        flush_a;
        logic [2:0]  flush_cnt;
        logic [2:0]  blen;

        n = 3'd0;
        for (int i = 0; i < utf8d_pkg::MAX_RESULTS; i++)
            res_next[i] = '{cp: 21'd0, inv: 1'b0};
        for (int i = 0; i < 3; i++)
            pe[i] = (cont_in_seq && (ccnt_reg == i[1:0])) ?
                    (data_byte[5:0] & utf8d_pkg::PAY_MASK) : pay_reg[i];

        ncnt = {1'b0, ccnt_reg} + 3'd1;
        fin  = (ncnt + 3'd1) >= len_reg;

        case (len_reg)
            utf8d_pkg::LEN_TWO:
            begin
                u    = {10'd0, lead_reg[4:0], pe[0]};
                good = u >= utf8d_pkg::MIN_TWO;
            end
            utf8d_pkg::LEN_THREE:
            begin
                u    = {5'd0, lead_reg[3:0], pe[0], pe[1]};
                good = u >= utf8d_pkg::MIN_THREE;
            end
            utf8d_pkg::LEN_FOUR:
            begin
                u    = {lead_reg[2:0], pe[0], pe[1], pe[2]};
                good = (u >= utf8d_pkg::MIN_FOUR) && (u <= utf8d_pkg::MAX_CP);
            end
            default:
            begin
                u    = 21'd0;
                good = 1'b0;
            end
        endcase

        // a break, or a completed sequence that is overlong or too large
        flush_a   = open_seq && (!is_cont || (fin && !good));
        flush_cnt = is_cont ? ncnt : {1'b0, ccnt_reg};

        lead_next = lead_reg;
        len_next  = len_reg;
        ccnt_next = ccnt_reg;

        if (flush_a)
        begin
            res_next[n[1:0]] = '{cp: {13'd0, lead_reg}, inv: 1'b1};
            n = n + 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                if (i[2:0] < flush_cnt)
                begin
                    res_next[n[1:0]] = '{cp: {13'd0, utf8d_pkg::CONT_MARK[7:6], pe[i]},
                                         inv: 1'b1};
                    n = n + 3'd1;
                end
            end
        end

        blen = utf8d_pkg::lead_length(data_byte);
        if (cont_in_seq)
        begin
            if (fin)
            begin
                if (good)
                begin
                    res_next[n[1:0]] = '{cp: u, inv: 1'b0};
                    n = n + 3'd1;
                end
                lead_next = 8'd0;
                len_next  = utf8d_pkg::LEN_NONE;
                ccnt_next = 2'd0;
            end
            else
                ccnt_next = ncnt[1:0];
        end
        else
        begin
            lead_next = 8'd0;
            len_next  = utf8d_pkg::LEN_NONE;
            ccnt_next = 2'd0;
            if (blen == utf8d_pkg::LEN_ASCII)
            begin
                res_next[n[1:0]] = '{cp: {13'd0, data_byte}, inv: 1'b0};
                n = n + 3'd1;
            end
            else if (blen == utf8d_pkg::LEN_NONE)
            begin
                res_next[n[1:0]] = '{cp: {13'd0, data_byte}, inv: 1'b1};
                n = n + 3'd1;
            end
            else
            begin
                lead_next = data_byte;
                len_next  = blen;
            end
        end

        if (end_of_data && (len_next != utf8d_pkg::LEN_NONE))
        begin
            res_next[n[1:0]] = '{cp: {13'd0, lead_next}, inv: 1'b1};
            n = n + 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                if (i[1:0] < ccnt_next && i < 2)
                begin
                    res_next[n[1:0]] = '{cp: {13'd0, utf8d_pkg::CONT_MARK[7:6], pe[i]},
                                         inv: 1'b1};
                    n = n + 3'd1;
                end
            end
            lead_next = 8'd0;
            len_next  = utf8d_pkg::LEN_NONE;
            ccnt_next = 2'd0;
        end

        cnt_next = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= 8'd0;
            len_reg  <= utf8d_pkg::LEN_NONE;
            ccnt_reg <= 2'd0;
            cnt_reg  <= 3'd0;
            rd_reg   <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                lead_reg <= lead_next;
                len_reg  <= len_next;
                ccnt_reg <= ccnt_next;
                cnt_reg  <= cnt_next;
                rd_reg   <= 2'd0;
            end
            else if (out_fire)
            begin
                if (last_one)
                begin
                    cnt_reg <= 3'd0;
                    rd_reg  <= 2'd0;
                end
                else
                    rd_reg <= rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < utf8d_pkg::MAX_RESULTS; i++)
                buf_reg[i] <= res_next[i];
            if (cont_in_seq)
                pay_reg[ccnt_reg] <= data_byte[5:0] & utf8d_pkg::PAY_MASK;
        end
    end

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg > {1'b0, rd_reg}) && (cnt_reg <= 3'd4))
        else $error("result read index beyond buffered results");

    a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == utf8d_pkg::LEN_NONE) || (len_reg == utf8d_pkg::LEN_TWO) ||
        (len_reg == utf8d_pkg::LEN_THREE) || (len_reg == utf8d_pkg::LEN_FOUR))
        else $error("bad open sequence length");

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != utf8d_pkg::LEN_NONE) |-> (({1'b0, ccnt_reg} + 3'd1) < len_reg))
        else $error("open sequence holds too many continuation bytes");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cnt_reg != 3'd0)) |-> (out_fire && last_one))
        else $error("transaction accepted over undelivered results");

    a_eod_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_data) |=> (len_reg == utf8d_pkg::LEN_NONE))
        else $error("sequence left open after end of data");

endmodule

FILE: tb/utf8_stream_decoder_test.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_test;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 250;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [7:0] STALL_PAT = 8'b1011_0110;

    // n == BY_MODEL: row is checked against the predictor, not typed values
    localparam logic [2:0] BY_MODEL = 3'd7;

    typedef struct packed {
        logic [7:0]  b;
        logic        eod;
        logic [2:0]  n;
        logic [3:0]  inv;
        logic [20:0] c0;
        logic [20:0] c1;
        logic [20:0] c2;
        logic [20:0] c3;
    } dir_row_t;

    typedef struct {
        logic [20:0] cp;
        logic        inv;
        logic        last;
    } cp_result_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{8'h00, 1'b0, 3'd1, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'hFF, 1'b0, 3'd1, 4'b0001, 21'hFF, 21'h00, 21'h00, 21'h00},
        '{8'h80, 1'b0, 3'd1, 4'b0001, 21'h80, 21'h00, 21'h00, 21'h00},
        '{8'h7F, 1'b0, BY_MODEL, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        // largest scalar value
        '{8'hF4, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'h8F, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'hBF, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'hBF, 1'b0, BY_MODEL, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        // overlong two-byte form
        '{8'hC0, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'h80, 1'b0, 3'd2, 4'b0011, 21'hC0, 21'h80, 21'h00, 21'h00},
        // surrogate passes through
        '{8'hED, 1'b0, BY_MODEL, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'hA0, 1'b0, BY_MODEL, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'h80, 1'b0, BY_MODEL, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        // above 10FFFF
        '{8'hF4, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'h90, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'h80, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'h80, 1'b0, 3'd4, 4'b1111, 21'hF4, 21'h90, 21'h80, 21'h80},
        // broken by an ASCII byte
        '{8'hE2, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'h41, 1'b0, 3'd2, 4'b0001, 21'hE2, 21'h41, 21'h00, 21'h00},
        // end of data inside a sequence
        '{8'hE2, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'h82, 1'b1, 3'd2, 4'b0011, 21'hE2, 21'h82, 21'h00, 21'h00},
        '{8'hC3, 1'b1, 3'd1, 4'b0001, 21'hC3, 21'h00, 21'h00, 21'h00},
        '{8'h7F, 1'b1, BY_MODEL, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'hC2, 1'b0, 3'd0, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00},
        '{8'hA9, 1'b0, BY_MODEL, 4'b0000, 21'h00, 21'h00, 21'h00, 21'h00}
    };

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte   = 8'h00;
    logic        end_of_data = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [20:0] code_point;
    logic        invalid_byte;
    logic        last_of_run;

    utf8_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_data  (end_of_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_point   (code_point),
        .invalid_byte (invalid_byte),
        .last_of_run  (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // decoder state mirror
    logic [7:0] open_lead = 8'h00;
    logic [2:0] open_len  = utf8d_pkg::LEN_NONE;
    logic [1:0] cont_cnt  = 2'd0;
    logic [5:0] cont_pay [3];

    cp_result_t decoded_q [$];
    cp_result_t cp_expect_q [$];
    int         row_tag_q [$];

    int  fail_cnt      = 0;
    int  cyc_cnt       = 0;
    int  burst_left    = 0;
    int  bytes_sent    = 0;
    int  eod_sent      = 0;
    int  results_seen  = 0;
    int  invalid_seen  = 0;
    bit  hold_req      = 1'b0;
    bit  hold_done     = 1'b0;

    function automatic void emit(input logic [20:0] cp, input logic inv);
        if (decoded_q.size() < utf8d_pkg::MAX_RESULTS)
            decoded_q.push_back('{cp: cp, inv: inv, last: 1'b0});
    endfunction

    function automatic void drop_open();
        emit(21'(open_lead), 1'b1);
        for (int i = 0; i < int'(cont_cnt); i++)
            emit(21'({2'b10, cont_pay[i]}), 1'b1);
        open_lead = 8'h00;
        open_len  = utf8d_pkg::LEN_NONE;
        cont_cnt  = 2'd0;
    endfunction

    function automatic logic [2:0] opened_len(input logic [7:0] b);
        if (b >= utf8d_pkg::LEAD_LIMIT)
            return utf8d_pkg::LEN_NONE;
        if (b >= utf8d_pkg::LEAD4_MIN)
            return utf8d_pkg::LEN_FOUR;
        if (b >= utf8d_pkg::LEAD3_MIN)
            return utf8d_pkg::LEN_THREE;
        if (b >= utf8d_pkg::LEAD2_MIN)
            return utf8d_pkg::LEN_TWO;
        if (b >= utf8d_pkg::CONT_MARK)
            return utf8d_pkg::LEN_NONE;
        return utf8d_pkg::LEN_ASCII;
    endfunction

    function automatic logic [2:0] shortest_len(input logic [20:0] u);
        if (u < utf8d_pkg::MIN_TWO)
            return utf8d_pkg::LEN_ASCII;
        if (u < utf8d_pkg::MIN_THREE)
            return utf8d_pkg::LEN_TWO;
        if (u < utf8d_pkg::MIN_FOUR)
            return utf8d_pkg::LEN_THREE;
        if (u <= utf8d_pkg::MAX_CP)
            return utf8d_pkg::LEN_FOUR;
        return utf8d_pkg::LEN_NONE;
    endfunction

    function automatic void close_seq();
        logic [20:0] u;
        u = 21'(open_lead) & ((21'd1 << (7 - int'(open_len))) - 21'd1);
        for (int k = 0; k < int'(open_len) - 1; k++)
            u = (u << 6) | 21'(cont_pay[k]);
        if (shortest_len(u) == open_len)
        begin
            emit(u, 1'b0);
            open_lead = 8'h00;
            open_len  = utf8d_pkg::LEN_NONE;
            cont_cnt  = 2'd0;
        end
        else
            drop_open();
    endfunction

    // results of one byte land in decoded_q
    function automatic void decode_byte(input logic [7:0] b, input logic eod);
        logic [2:0] len;
        bit         taken;
        taken = 1'b0;
        decoded_q.delete();
        if (open_len != utf8d_pkg::LEN_NONE)
        begin
            if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_MARK)
            begin
                cont_pay[cont_cnt] = b[5:0];
                cont_cnt = cont_cnt + 2'd1;
                if (int'(cont_cnt) + 1 >= int'(open_len))
                    close_seq();
                taken = 1'b1;
            end
            else
                drop_open();
        end
        if (!taken)
        begin
            len = opened_len(b);
            if (len == utf8d_pkg::LEN_ASCII)
                emit(21'(b), 1'b0);
            else if (len != utf8d_pkg::LEN_NONE)
            begin
                open_lead = b;
                open_len  = len;
                cont_cnt  = 2'd0;
            end
            else
                emit(21'(b), 1'b1);
        end
        if (eod && open_len != utf8d_pkg::LEN_NONE)
            drop_open();
        if (decoded_q.size() > 0)
            decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void cmp_field(input string name, input logic [20:0] want,
                                      input logic [20:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        int         tag;
        dir_row_t   row;
        logic [20:0] tcp [4];
        cp_result_t want;
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cyc_cnt, cp_expect_q.size());
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
        begin
            tag = row_tag_q.pop_front();
            decode_byte(data_byte, end_of_data);
            if (tag >= 0 && DIR_TAB[tag].n != BY_MODEL)
            begin
                row = DIR_TAB[tag];
                tcp = '{row.c0, row.c1, row.c2, row.c3};
                for (int k = 0; k < int'(row.n); k++)
                    cp_expect_q.push_back('{cp: tcp[k], inv: row.inv[k],
                                            last: (k == int'(row.n) - 1)});
            end
            else
                foreach (decoded_q[k])
                    cp_expect_q.push_back(decoded_q[k]);
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (invalid_byte)
                invalid_seen++;
            if (cp_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got cp=%0h inv=%0b last=%0b",
                         $time, code_point, invalid_byte, last_of_run);
                fail_cnt++;
            end
            else
            begin
                want = cp_expect_q.pop_front();
                cmp_field("code_point", want.cp, code_point);
                cmp_field("invalid_byte", 21'(want.inv), 21'(invalid_byte));
                cmp_field("last_of_run", 21'(want.last), 21'(last_of_run));
            end
        end
    end

    // output side: segments of steady, random and patterned back-pressure, with one long stall
    initial
    begin
        int seg_len;
        int kind;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            seg_len = $urandom_range(10, 60);
            kind    = $urandom_range(0, 3);
            for (int k = 0; k < seg_len; k++)
            begin
                case (kind)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= STALL_PAT[cyc_cnt % 8];
                    default: out_ready <= 1'($urandom_range(0, 1));
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eod, input int tag);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        row_tag_q.push_back(tag);
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_data <= eod;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
        if (eod)
            eod_sent++;
    endtask

    function automatic logic [3:0][7:0] encode_cp(input logic [20:0] cp, input int len);
        logic [3:0][7:0] enc;
        enc = '0;
        case (len)
            2: enc = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            3: enc = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            default: enc = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                            5'b11110, cp[20:18]};
        endcase
        return enc;
    endfunction

    initial
    begin
        int              pick;
        int              len;
        int              keep;
        logic [20:0]     cp;
        logic [3:0][7:0] enc;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TAB[i].b, DIR_TAB[i].eod, i);

        hold_req = 1'b1;
        while (bytes_sent < DIR_ROWS + RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(2, 4);
            keep = len;
            case (len)
                2: cp = 21'($urandom_range(21'h7FF, 21'h080));
                3: cp = ($urandom_range(0, 4) == 0) ?
                        21'($urandom_range(21'hDFFF, 21'hD800)) :
                        21'($urandom_range(21'hFFFF, 21'h0800));
                default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            endcase
            if (pick < 25)
            begin
                len  = 1;
                keep = 1;
                cp   = 21'($urandom_range(0, 127));
            end
            else if (pick < 55)
            begin
                // shortest-form multi-byte sequence (surrogates included)
            end
            else if (pick < 63)
            begin
                // overlong: value fits a shorter form
                case (len)
                    2: cp = 21'($urandom_range(21'h07F, 0));
                    3: cp = 21'($urandom_range(21'h07FF, 0));
                    default: cp = 21'($urandom_range(21'hFFFF, 0));
                endcase
            end
            else if (pick < 70)
            begin
                len  = 4;
                keep = 4;
                cp   = 21'($urandom_range(21'h13FFFF, 21'h110000));
            end
            else if (pick < 80)
                keep = $urandom_range(1, len - 1);
            else
            begin
                len  = 1;
                keep = 1;
                if (pick < 88)
                    cp = 21'($urandom_range(8'hBF, 8'h80));
                else if (pick < 93)
                    cp = 21'($urandom_range(8'hFF, 8'hF5));
                else
                    cp = 21'($urandom_range(8'hFF, 8'h00));
            end
            enc = (len == 1) ? {24'h0, cp[7:0]} : encode_cp(cp, len);
            for (int k = 0; k < keep; k++)
                send_byte(enc[k], ($urandom_range(0, 24) == 0), -1);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (cp_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes (%0d flagged end-of-data), %0d results checked,",
                 bytes_sent, eod_sent, results_seen);
        $display("%0d of them invalid raw bytes, one long output stall", invalid_seen);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8_stream_decoder.sv
tb/utf8_stream_decoder_test.sv
